// File: design/prctab_pkg.sv
// Shared constants, codes and types of the page retire counter table.
`default_nettype none
package prctab_pkg;

    // Address layout
    localparam int PAGE_SHIFT    = 12;
    localparam int SEGMENT_SHIFT = 20;
    localparam int ADDR_W        = 48;
    localparam int PN_W          = 36;
    localparam int PIS_W         = SEGMENT_SHIFT - PAGE_SHIFT;

    // Field widths
    localparam int CNT_W      = 16;
    localparam int CAP_W      = 12;
    localparam int SHARD_W    = 8;
    localparam int SLOT_W     = 12;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // Bit counter width for the serial home-slot reduction over a page number
    localparam int PN_BIT_W = $clog2(PN_W);

    localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
    localparam logic [CAP_W-1:0]   CAP_RESET   = 12'd256;
    localparam logic [SHARD_W-1:0] SHARD_RESET = 8'd0;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARD_ID      = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_COUNTED    = 3'd0,
        ST_RETIRED    = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_FULL_KEPT  = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_CLEARED    = 3'd5,
        ST_SLOT_KEPT  = 3'd6,
        ST_SLOT_EMPTY = 3'd7
    } status_t;

    // One table slot
    typedef struct packed {
        logic             valid;
        logic             retired;
        logic [CNT_W-1:0] count;
        logic [PN_W-1:0]  key;
    } entry_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_SLOT,
        S_EMIT
    } state_t;

endpackage
`default_nettype wire

// File: design/prctab_mod.sv
// Home-slot unit: page number modulo the table depth.
`default_nettype none
module prctab_mod #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [prctab_pkg::PN_W-1:0]      pn,
    output logic                                  done,
    output logic [$clog2(TABLE_DEPTH)-1:0]        home
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    generate
        if ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0) begin : g_mask
            // Power-of-two depth: the low bits are the remainder
            logic             done_reg;
            logic [IDX_W-1:0] home_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    home_reg <= pn[IDX_W-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end else begin : g_serial
            // Restoring remainder, one page-number bit a cycle, MSB first
            localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(TABLE_DEPTH);

            logic                              busy_reg, busy_next;
            logic                              done_reg, done_next;
            logic [prctab_pkg::PN_BIT_W-1:0]   bit_reg, bit_next;
            logic [prctab_pkg::PN_W-1:0]       sh_reg, sh_next;
            logic [IDX_W-1:0]                  rem_reg, rem_next;
            logic [IDX_W:0]                    trial;

            always_comb begin
                trial     = {rem_reg, sh_reg[prctab_pkg::PN_W-1]};
                busy_next = busy_reg;
                done_next = 1'b0;
                bit_next  = bit_reg;
                sh_next   = sh_reg;
                rem_next  = rem_reg;
                if (start) begin
                    busy_next = 1'b1;
                    bit_next  = prctab_pkg::PN_BIT_W'(prctab_pkg::PN_W - 1);
                    sh_next   = pn;
                    rem_next  = '0;
                end else if (busy_reg) begin
                    if (trial >= DEPTH_C) begin
                        rem_next = IDX_W'(trial - DEPTH_C);
                    end else begin
                        rem_next = trial[IDX_W-1:0];
                    end
                    sh_next  = {sh_reg[prctab_pkg::PN_W-2:0], 1'b0};
                    bit_next = bit_reg - 1'b1;
                    if (bit_reg == '0) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                end else begin
                    busy_reg <= busy_next;
                    done_reg <= done_next;
                end
            end

            always_ff @(posedge aclk) begin
                bit_reg <= bit_next;
                sh_reg  <= sh_next;
                rem_reg <= rem_next;
            end

            assign done = done_reg;
            assign home = rem_reg;
        end
    endgenerate

endmodule
`default_nettype wire

// File: design/prctab_ram.sv
// Single-port slot memory with registered read data.
`default_nettype none
module prctab_ram #(
    parameter int DEPTH = 4096
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   addr,
    input  wire prctab_pkg::entry_t         wdata,
    output prctab_pkg::entry_t              rdata
);

    prctab_pkg::entry_t mem [DEPTH];
    prctab_pkg::entry_t rdata_reg;

    // Write has the port; otherwise read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: design/page_retire_counter_table.sv
// Top level of the page retire counter table: sequencer, registers and output word.
`default_nettype none
// Freed object addresses are counted per page in a linear-probing hash table
// of TABLE_DEPTH slots held in one single-port memory. An add word is accepted,
// its home slot is computed, slots are probed from there, up to every slot of a
// full table, and the result is handed to the output register. With a depth
// that is not a power of two the home slot comes from a serial remainder unit.
// The single memory port sets the probe rate of one slot a cycle. A clear word,
// and the clearing pass after reset, sweep the memory one slot a cycle with
// s_ready low. The next word is taken while a result still waits at the output.
module page_retire_counter_table #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // input words
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic [prctab_pkg::MODE_W-1:0]           s_mode,
    input  wire logic [prctab_pkg::ADDR_W-1:0]           s_object_addr,
    input  wire logic                                    s_seg_header_valid,
    input  wire logic [prctab_pkg::SHARD_W-1:0]          s_seg_owner,
    input  wire logic [prctab_pkg::SLOT_W-1:0]           s_slot_index,
    // result words
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [prctab_pkg::STATUS_W-1:0]              m_status,
    output logic [prctab_pkg::PN_W-1:0]                  m_page_number,
    output logic [prctab_pkg::PIS_W-1:0]                 m_page_in_segment,
    output logic [prctab_pkg::CNT_W-1:0]                 m_object_count,
    // configuration
    input  wire logic                                    cfg_we,
    input  wire logic [prctab_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [prctab_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SLOT_EXT_W = (IDX_W > prctab_pkg::SLOT_W) ? IDX_W : prctab_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

    prctab_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] probe_reg, probe_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;
    logic             clr_item_reg, clr_item_next;
    logic             m_valid_reg, m_valid_next;

    // captured input word
    logic [prctab_pkg::PN_W-1:0]    pn_reg;
    logic [prctab_pkg::PIS_W-1:0]   pis_reg;
    logic                           seg_valid_reg;
    logic [prctab_pkg::SHARD_W-1:0] seg_owner_reg;
    logic                           slot_ok_reg;

    // configuration registers
    logic [prctab_pkg::CAP_W-1:0]   cap_reg;
    logic [prctab_pkg::SHARD_W-1:0] shard_reg;

    // pending result and output word
    prctab_pkg::status_t            res_status_reg, res_status_next;
    logic [prctab_pkg::PN_W-1:0]    res_pn_reg, res_pn_next;
    logic [prctab_pkg::PIS_W-1:0]   res_pis_reg, res_pis_next;
    logic [prctab_pkg::CNT_W-1:0]   res_cnt_reg, res_cnt_next;
    prctab_pkg::status_t            m_status_reg;
    logic [prctab_pkg::PN_W-1:0]    m_pn_reg;
    logic [prctab_pkg::PIS_W-1:0]   m_pis_reg;
    logic [prctab_pkg::CNT_W-1:0]   m_cnt_reg;
    logic                           load_out;

    // memory and home-slot unit
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_addr;
    prctab_pkg::entry_t   ram_wdata;
    prctab_pkg::entry_t   ram_rdata;
    logic                 mod_start;
    logic                 mod_done;
    logic [IDX_W-1:0]     mod_home;

    // probe evaluation
    logic                           s_fire;
    logic [SLOT_EXT_W-1:0]          slot_ext;
    logic                           slot_in_range;
    logic [IDX_W-1:0]               idx_wrap;
    logic                           hit;
    logic [prctab_pkg::CNT_W-1:0]   cnt_old;
    logic [prctab_pkg::CNT_W-1:0]   cnt_new;
    logic                           ret_old;
    logic                           cnt_sat;
    logic                           at_cap;
    logic                           retire_ok;

    assign s_fire        = s_valid && s_ready;
    assign s_ready       = (state_reg == prctab_pkg::S_IDLE);
    assign slot_ext      = SLOT_EXT_W'(s_slot_index);
    assign slot_in_range = (32'(s_slot_index) < 32'(TABLE_DEPTH));
    assign idx_wrap      = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;

    prctab_mod #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .pn      (s_object_addr[prctab_pkg::PAGE_SHIFT +: prctab_pkg::PN_W]),
        .done    (mod_done),
        .home    (mod_home)
    );

    prctab_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Slot just read: match, count update and retirement check
    always_comb begin
        hit       = !ram_rdata.valid || (ram_rdata.key == pn_reg);
        cnt_old   = ram_rdata.valid ? ram_rdata.count : '0;
        ret_old   = ram_rdata.valid && ram_rdata.retired;
        cnt_sat   = (cnt_old == prctab_pkg::CNT_MAX);
        cnt_new   = cnt_sat ? cnt_old : cnt_old + 1'b1;
        at_cap    = !cnt_sat && (cnt_new == prctab_pkg::CNT_W'(cap_reg));
        retire_ok = at_cap && (pis_reg != '0) && seg_valid_reg && (seg_owner_reg == shard_reg);
    end

    // Sequencer: next state, memory port and pending result
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        probe_next      = probe_reg;
        clr_addr_next   = clr_addr_reg;
        clr_item_next   = clr_item_reg;
        res_status_next = res_status_reg;
        res_pn_next     = res_pn_reg;
        res_pis_next    = res_pis_reg;
        res_cnt_next    = res_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        load_out        = 1'b0;
        mod_start       = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = idx_reg;
        ram_wdata       = '0;
        case (state_reg)
            prctab_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                if (clr_addr_reg == LAST_SLOT) begin
                    clr_addr_next = '0;
                    clr_item_next = 1'b0;
                    if (clr_item_reg) begin
                        res_status_next = prctab_pkg::ST_CLEARED;
                        res_pn_next     = '0;
                        res_pis_next    = '0;
                        res_cnt_next    = '0;
                        state_next      = prctab_pkg::S_EMIT;
                    end else begin
                        state_next = prctab_pkg::S_IDLE;
                    end
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            prctab_pkg::S_IDLE: begin
                ram_addr = slot_ext[IDX_W-1:0];
                if (s_fire) begin
                    case (s_mode)
                        prctab_pkg::MODE_ADD: begin
                            mod_start  = 1'b1;
                            state_next = prctab_pkg::S_HASH;
                        end
                        prctab_pkg::MODE_CLEAR: begin
                            clr_item_next = 1'b1;
                            clr_addr_next = '0;
                            state_next    = prctab_pkg::S_CLEAR;
                        end
                        prctab_pkg::MODE_READ: begin
                            state_next = prctab_pkg::S_SLOT;
                        end
                        default: begin
                            state_next = prctab_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            prctab_pkg::S_HASH: begin
                if (mod_done) begin
                    ram_addr   = mod_home;
                    idx_next   = mod_home;
                    probe_next = '0;
                    state_next = prctab_pkg::S_PROBE;
                end
            end
            prctab_pkg::S_PROBE: begin
                res_pn_next  = pn_reg;
                res_pis_next = '0;
                if (hit) begin
                    state_next = prctab_pkg::S_EMIT;
                    if (ret_old) begin
                        res_status_next = prctab_pkg::ST_DROPPED;
                        res_cnt_next    = cnt_old;
                    end else begin
                        ram_we            = 1'b1;
                        ram_addr          = idx_reg;
                        ram_wdata.valid   = 1'b1;
                        ram_wdata.retired = retire_ok;
                        ram_wdata.count   = cnt_new;
                        ram_wdata.key     = pn_reg;
                        res_cnt_next      = cnt_new;
                        if (at_cap) begin
                            res_pis_next    = pis_reg;
                            res_status_next = retire_ok ? prctab_pkg::ST_RETIRED
                                                        : prctab_pkg::ST_FULL_KEPT;
                        end else begin
                            res_status_next = prctab_pkg::ST_COUNTED;
                        end
                    end
                end else if (probe_reg == LAST_SLOT) begin
                    res_status_next = prctab_pkg::ST_TABLE_FULL;
                    res_cnt_next    = '0;
                    state_next      = prctab_pkg::S_EMIT;
                end else begin
                    // read the next slot while this one is judged
                    ram_addr   = idx_wrap;
                    idx_next   = idx_wrap;
                    probe_next = probe_reg + 1'b1;
                end
            end
            prctab_pkg::S_SLOT: begin
                res_pis_next = '0;
                state_next   = prctab_pkg::S_EMIT;
                if (!slot_ok_reg || !ram_rdata.valid) begin
                    res_status_next = prctab_pkg::ST_SLOT_EMPTY;
                    res_pn_next     = '0;
                    res_cnt_next    = '0;
                end else begin
                    res_status_next = ram_rdata.retired ? prctab_pkg::ST_SLOT_EMPTY
                                                        : prctab_pkg::ST_SLOT_KEPT;
                    res_pn_next     = ram_rdata.key;
                    res_cnt_next    = ram_rdata.count;
                end
            end
            prctab_pkg::S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = prctab_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = prctab_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= prctab_pkg::S_CLEAR;
            clr_addr_reg <= '0;
            clr_item_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            idx_reg      <= '0;
            probe_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_item_reg <= clr_item_next;
            m_valid_reg  <= m_valid_next;
            idx_reg      <= idx_next;
            probe_reg    <= probe_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= prctab_pkg::CAP_RESET;
            shard_reg <= prctab_pkg::SHARD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                prctab_pkg::CFG_PAGE_CAPACITY: cap_reg   <= cfg_wdata[prctab_pkg::CAP_W-1:0];
                prctab_pkg::CFG_SHARD_ID:      shard_reg <= cfg_wdata[prctab_pkg::SHARD_W-1:0];
                default: begin
                    cap_reg <= cap_reg;
                end
            endcase
        end
    end

    // Input word capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pn_reg        <= s_object_addr[prctab_pkg::PAGE_SHIFT +: prctab_pkg::PN_W];
            pis_reg       <= s_object_addr[prctab_pkg::SEGMENT_SHIFT-1:prctab_pkg::PAGE_SHIFT];
            seg_valid_reg <= s_seg_header_valid;
            seg_owner_reg <= s_seg_owner;
            slot_ok_reg   <= slot_in_range;
        end
    end

    // Pending result and output word
    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_pn_reg     <= res_pn_next;
        res_pis_reg    <= res_pis_next;
        res_cnt_reg    <= res_cnt_next;
        if (load_out) begin
            m_status_reg <= res_status_reg;
            m_pn_reg     <= res_pn_reg;
            m_pis_reg    <= res_pis_reg;
            m_cnt_reg    <= res_cnt_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_page_number     = m_pn_reg;
    assign m_page_in_segment = m_pis_reg;
    assign m_object_count    = m_cnt_reg;

    // Checks
    a_clear_word_sweeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_mode == prctab_pkg::MODE_CLEAR)
        |=> (state_reg == prctab_pkg::S_CLEAR && clr_addr_reg == '0 && clr_item_reg))
        else $error("clear word did not start a sweep");

    a_probe_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prctab_pkg::S_PROBE) |-> (32'(idx_reg) < 32'(TABLE_DEPTH)))
        else $error("probe index beyond table");

    a_write_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == prctab_pkg::S_CLEAR || state_reg == prctab_pkg::S_PROBE))
        else $error("memory written outside sweep or probe");

    a_retire_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == prctab_pkg::ST_RETIRED)
        |-> (m_object_count == prctab_pkg::CNT_W'(cap_reg) && m_page_in_segment != '0))
        else $error("retired word with wrong count or segment index");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prctab_pkg::S_EMIT && (!m_valid || m_ready))
        |=> (m_valid && state_reg == prctab_pkg::S_IDLE))
        else $error("result word not loaded");

endmodule
`default_nettype wire
